@@ rtl/cmc_pkg.sv @@
`default_nettype none

package cmc_pkg;

  // fixed field widths
  localparam int COLOR_W      = 8;
  localparam int TOLERANCE_W  = 9;
  localparam int FRAME_SIZE_W = 12;
  localparam int CENTER_W     = 11;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 12;
  localparam int DIST_W       = 18;

  // reset values of the configuration registers
  localparam logic [COLOR_W-1:0]      RESET_TARGET_BLUE  = 8'd29;
  localparam logic [COLOR_W-1:0]      RESET_TARGET_GREEN = 8'd228;
  localparam logic [COLOR_W-1:0]      RESET_TARGET_RED   = 8'd200;
  localparam logic [TOLERANCE_W-1:0]  RESET_TOLERANCE    = 9'd80;
  localparam logic [FRAME_SIZE_W-1:0] RESET_FRAME_WIDTH  = 12'd640;
  localparam logic [FRAME_SIZE_W-1:0] RESET_FRAME_HEIGHT = 12'd480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_BLUE   = 3'd0,
    REG_TARGET_GREEN  = 3'd1,
    REG_TARGET_RED    = 3'd2,
    REG_TOLERANCE     = 3'd3,
    REG_FRAME_WIDTH   = 3'd4,
    REG_FRAME_HEIGHT  = 3'd5
  } cmc_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_blue;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_red;
  } cmc_pixel_t;

  typedef struct packed {
    logic                in_mask;
    logic                frame_done;
    logic                found;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
  } cmc_result_t;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } cmc_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_pixel;
    logic load_center;
  } cmc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
    logic div_done;
    logic out_free;
  } cmc_status_t;

endpackage

`default_nettype wire

@@ rtl/cmc_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle
// needs dividend < divisor * 2**QW, which holds for a mean of values below 2**QW
module cmc_div #(
  parameter int NW = 23,
  parameter int QW = 11
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NW+QW-1:0] dividend,
  input  wire logic [NW-1:0]    divisor,
  output logic      [QW-1:0]    quotient,
  output logic                  done
);

  localparam int SCW = $clog2(QW + 1);

  logic [NW-1:0]  rem;
  logic [QW-1:0]  low;
  logic [NW-1:0]  dvs;
  logic [SCW-1:0] step;
  logic           busy;

  logic [NW:0]    trial;
  logic [NW:0]    diff;
  logic           qbit;
  logic [QW:0]    low_shift;

  assign trial     = {rem, low[QW-1]};
  assign diff      = trial - {1'b0, dvs};
  assign qbit      = (trial >= {1'b0, dvs});
  assign low_shift = {low, qbit};
  assign quotient  = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      if (step == SCW'(QW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      step <= step + SCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[NW+QW-1:QW];
      low <= dividend[QW-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= qbit ? diff[NW-1:0] : trial[NW-1:0];
      low <= low_shift[QW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/cmc_datapath.sv @@
`default_nettype none

module cmc_datapath import cmc_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire cmc_pixel_t             in_pixel,
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output cmc_result_t                 out_result,
  input  wire cmc_cmd_t               cmd,
  output cmc_status_t                 status
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int NW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int QW  = (CW > RW) ? CW : RW;
  localparam int DW  = NW + QW;
  localparam int WLW = ($clog2(MAX_WIDTH + 1) > FRAME_SIZE_W) ?
                       $clog2(MAX_WIDTH + 1) : FRAME_SIZE_W;
  localparam int HLW = ($clog2(MAX_HEIGHT + 1) > FRAME_SIZE_W) ?
                       $clog2(MAX_HEIGHT + 1) : FRAME_SIZE_W;
  localparam int XW  = (QW > CENTER_W) ? QW : CENTER_W;

  // configuration registers
  logic [COLOR_W-1:0]      target_blue;
  logic [COLOR_W-1:0]      target_green;
  logic [COLOR_W-1:0]      target_red;
  logic [TOLERANCE_W-1:0]  tolerance;
  logic [FRAME_SIZE_W-1:0] frame_width;
  logic [FRAME_SIZE_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_blue  <= RESET_TARGET_BLUE;
      target_green <= RESET_TARGET_GREEN;
      target_red   <= RESET_TARGET_RED;
      tolerance    <= RESET_TOLERANCE;
      frame_width  <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_BLUE:  target_blue  <= cfg_data[COLOR_W-1:0];
        REG_TARGET_GREEN: target_green <= cfg_data[COLOR_W-1:0];
        REG_TARGET_RED:   target_red   <= cfg_data[COLOR_W-1:0];
        REG_TOLERANCE:    tolerance    <= cfg_data[TOLERANCE_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // color distance test
  function automatic logic [2*COLOR_W-1:0] sq_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {{COLOR_W{1'b0}}, d} * {{COLOR_W{1'b0}}, d};
  endfunction

  logic [DIST_W-1:0] dist_sq;
  logic [DIST_W-1:0] tol_sq;
  logic              hit;

  assign dist_sq = DIST_W'(sq_diff(in_pixel.pixel_blue, target_blue))
                 + DIST_W'(sq_diff(in_pixel.pixel_green, target_green))
                 + DIST_W'(sq_diff(in_pixel.pixel_red, target_red));
  assign tol_sq  = {{(DIST_W-TOLERANCE_W){1'b0}}, tolerance}
                 * {{(DIST_W-TOLERANCE_W){1'b0}}, tolerance};
  assign hit     = (dist_sq < tol_sq);

  // frame geometry
  logic [WLW-1:0] fw_ext, w_eff, w_last;
  logic [HLW-1:0] fh_ext, h_eff, h_last;

  assign fw_ext = WLW'(frame_width);
  assign fh_ext = HLW'(frame_height);
  assign w_eff  = (frame_width == '0) ? WLW'(1) :
                  (fw_ext > WLW'(MAX_WIDTH)) ? WLW'(MAX_WIDTH) : fw_ext;
  assign h_eff  = (frame_height == '0) ? HLW'(1) :
                  (fh_ext > HLW'(MAX_HEIGHT)) ? HLW'(MAX_HEIGHT) : fh_ext;
  assign w_last = w_eff - WLW'(1);
  assign h_last = h_eff - HLW'(1);

  logic [CW-1:0] column_counter;
  logic [RW-1:0] row_counter;
  logic [DW-1:0] sum_of_x, sum_of_y;
  logic [NW-1:0] match_count;

  logic          row_end, frame_end;
  logic [DW-1:0] sum_of_x_next, sum_of_y_next;
  logic [NW-1:0] match_count_next;

  assign row_end   = (WLW'(column_counter) >= w_last);
  assign frame_end = row_end && (HLW'(row_counter) >= h_last);

  assign sum_of_x_next    = sum_of_x + (hit ? DW'(column_counter) : '0);
  assign sum_of_y_next    = sum_of_y + (hit ? DW'(row_counter) : '0);
  assign match_count_next = match_count + NW'(hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      sum_of_x       <= '0;
      sum_of_y       <= '0;
      match_count    <= '0;
    end else if (cmd.take_pixel) begin
      if (frame_end) begin
        column_counter <= '0;
        row_counter    <= '0;
        sum_of_x       <= '0;
        sum_of_y       <= '0;
        match_count    <= '0;
      end else begin
        sum_of_x    <= sum_of_x_next;
        sum_of_y    <= sum_of_y_next;
        match_count <= match_count_next;
        if (row_end) begin
          column_counter <= '0;
          row_counter    <= row_counter + RW'(1);
        end else begin
          column_counter <= column_counter + CW'(1);
        end
      end
    end
  end

  // centroid division, x and y side by side
  logic          div_start;
  logic [QW-1:0] quot_x, quot_y;
  logic          done_x, done_y;

  assign div_start = cmd.take_pixel && frame_end;

  cmc_div #(.NW(NW), .QW(QW)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_of_x_next),
    .divisor  (match_count_next),
    .quotient (quot_x),
    .done     (done_x)
  );

  cmc_div #(.NW(NW), .QW(QW)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_of_y_next),
    .divisor  (match_count_next),
    .quotient (quot_y),
    .done     (done_y)
  );

  // held from the frame's last pixel until its result is loaded
  logic end_mask, end_found;

  always_ff @(posedge clk) begin
    if (div_start) begin
      end_mask  <= hit;
      end_found <= (match_count_next != '0);
    end
  end

  logic [XW-1:0] quot_x_ext, quot_y_ext;

  assign quot_x_ext = XW'(quot_x);
  assign quot_y_ext = XW'(quot_y);

  // output register
  logic out_free;
  logic load_pixel;

  assign out_free   = !out_valid || !out_stall;
  assign load_pixel = cmd.take_pixel && !frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_pixel || cmd.load_center) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pixel) begin
      out_result.in_mask    <= hit;
      out_result.frame_done <= 1'b0;
      out_result.found      <= 1'b0;
      out_result.center_x   <= '0;
      out_result.center_y   <= '0;
    end else if (cmd.load_center) begin
      out_result.in_mask    <= end_mask;
      out_result.frame_done <= 1'b1;
      out_result.found      <= end_found;
      out_result.center_x   <= end_found ? quot_x_ext[CENTER_W-1:0] : '0;
      out_result.center_y   <= end_found ? quot_y_ext[CENTER_W-1:0] : '0;
    end
  end

  assign status.frame_end = frame_end;
  assign status.div_done  = done_x && done_y;
  assign status.out_free  = out_free;

endmodule

`default_nettype wire

@@ rtl/cmc_ctrl.sv @@
`default_nettype none

module cmc_ctrl import cmc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire cmc_status_t status,
  output cmc_cmd_t         cmd
);

  cmc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_stall        = 1'b1;
    cmd.take_pixel  = 1'b0;
    cmd.load_center = 1'b0;
    case (state)
      ST_RUN: begin
        in_stall       = !status.out_free;
        cmd.take_pixel = in_valid && status.out_free;
        if (cmd.take_pixel && status.frame_end) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done && status.out_free) begin
          cmd.load_center = 1'b1;
          state_next      = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/color_mask_centroid.sv @@
// color threshold and blob centroid over a raster pixel stream
//
// pixel channel (in_valid / in_stall / in_pixel): one bgr pixel per transfer,
//   raster order, frame size taken from the frame_width / frame_height registers
// result channel (out_valid / out_stall / out_result): one result per pixel,
//   carrying the mask bit; the frame's last pixel also carries found and the
//   truncated mean column and row of the matched pixels
// config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready,
//   write only between frames or while idle
// rate: one pixel per cycle inside a frame while out_stall is low; each result
//   is registered in the output register the cycle after its pixel transfers
// frame end: the centroid comes from two restoring dividers working side by
//   side, one quotient bit per cycle; the last pixel's result is loaded once
//   both are done and the output register is free; no pixel is taken until then
// stall: a stalled result holds; the next pixel is taken in the same cycle the
//   waiting result transfers, otherwise the pixel channel stalls
// reset (rst, synchronous): registers back to their defaults, counters and
//   sums cleared, no result pending
`default_nettype none

module color_mask_centroid import cmc_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // pixel input
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire cmc_pixel_t             in_pixel,
  // result output
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output cmc_result_t                 out_result,
  // register writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cmc_cmd_t    cmd;
  cmc_status_t status;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencing: pixel transfers, divide wait, centroid load
  cmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // color test, counters, sums, dividers and output register
  cmc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_pixel   (in_pixel),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

`default_nettype wire
